[rtl/bottom_up_merge_sorter_macros.svh]
// Assertion helpers used by the cell RTL.
`ifndef BOTTOM_UP_MERGE_SORTER_MACROS_SVH
`define BOTTOM_UP_MERGE_SORTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BUMS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BUMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bums_pkg.sv]
`default_nettype none

package bums_pkg;

   localparam int SIZE       = 16;
   localparam int DATA_WIDTH = 32;

   typedef logic signed [DATA_WIDTH-1:0] bums_data_type;

   // Control broadcast to every cell of the chain.
   typedef struct packed {
      logic insert;
      logic shift_out;
   } bums_ctrl_type;

endpackage

`default_nettype wire

[rtl/bottom_up_merge_sorter.sv]
// Stable ascending sorter for one batch of signed 32-bit values.
// Input channel req_*: one value per transaction, req_last marks the batch end.
// Result channel rsp_*: the batch in ascending order, rsp_last_out on the final
// value, rsp_overflow set on every result when values beyond SIZE were dropped.
// Structure: a row of SIZE insertion cells, smallest value in cell 0. Each
// accepted value is broadcast to every cell; cells above the insertion point
// take their lower neighbor's value, so all cells update together when a value is placed.
// Equal values go behind those already held, which keeps arrival order.
// Throughput: one input transaction per cycle while collecting. After the
// last transaction the chain drains one value per accepted result, shifting
// toward cell 0; input is not taken until the final result is taken.
// Latency: the first result is valid the cycle after the last input.
// Receiver stall: cell 0 holds the pending result until rsp_ready.
// Reset clears all occupancy, the drain state and the overflow flag.
`default_nettype none

module bottom_up_merge_sorter
   import bums_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic signed [31:0]    req_value,
   input  wire logic                  req_last,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic signed [31:0]         rsp_sorted_value,
   output logic                       rsp_last_out,
   output logic                       rsp_overflow
);

   bums_data_type cell_value   [SIZE];
   logic          cell_valid   [SIZE];
   logic          cell_greater [SIZE];

   logic          draining_ff, draining_in;
   logic          dropped_ff, dropped_in;
   logic          req_take, rsp_take, full;
   bums_ctrl_type ctrl;

   assign req_ready = !draining_ff;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = draining_ff && cell_valid[0];
   assign rsp_take  = rsp_valid && rsp_ready;

   // Store is full once the top cell is occupied.
   assign full = cell_valid[SIZE-1];

   assign ctrl.insert    = req_take && !full;
   assign ctrl.shift_out = rsp_take;

   // Result comes straight from cell 0; the final one is when cell 1 is empty.
   assign rsp_sorted_value = cell_value[0];
   assign rsp_last_out     = !cell_valid[1];
   assign rsp_overflow     = dropped_ff;

   always_comb begin
      draining_in = draining_ff;
      dropped_in  = dropped_ff;
      if (req_take) begin
         // Drop the value when full, but remember it for the batch.
         if (full) begin
            dropped_in = 1'b1;
         end
         if (req_last) begin
            draining_in = 1'b1;
         end
      end
      if (rsp_take && rsp_last_out) begin
         // Batch done: release the input side and clear the overflow mark.
         draining_in = 1'b0;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         dropped_ff  <= dropped_in;
      end
   end

   for (genvar i = 0; i < SIZE; i++) begin : g_cell
      bums_data_type prev_value, next_value;
      logic          prev_valid, prev_greater, next_valid;

      if (i == 0) begin : g_head
         // Nothing sits below cell 0: it never takes a neighbor's value on insert.
         assign prev_value   = cell_value[0];
         assign prev_valid   = 1'b1;
         assign prev_greater = 1'b0;
      end else begin : g_body
         assign prev_value   = cell_value[i-1];
         assign prev_valid   = cell_valid[i-1];
         assign prev_greater = cell_greater[i-1];
      end

      if (i == SIZE-1) begin : g_tail
         // Shift an empty slot into the top cell while draining.
         assign next_value = cell_value[i];
         assign next_valid = 1'b0;
      end else begin : g_mid
         assign next_value = cell_value[i+1];
         assign next_valid = cell_valid[i+1];
      end

      bums_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .new_value    (req_value),
         .prev_value   (prev_value),
         .prev_valid   (prev_valid),
         .prev_greater (prev_greater),
         .next_value   (next_value),
         .next_valid   (next_valid),
         .value        (cell_value[i]),
         .valid        (cell_valid[i]),
         .greater      (cell_greater[i])
      );
   end

endmodule

`default_nettype wire

[rtl/bums_cell.sv]
`default_nettype none
`include "bottom_up_merge_sorter_macros.svh"

module bums_cell
   import bums_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire bums_ctrl_type ctrl,
   input  wire bums_data_type new_value,
   input  wire bums_data_type prev_value,
   input  wire logic          prev_valid,
   input  wire logic          prev_greater,
   input  wire bums_data_type next_value,
   input  wire logic          next_valid,
   output bums_data_type      value,
   output logic               valid,
   output logic               greater
);

   bums_data_type value_ff, value_in;
   logic          valid_ff, valid_in;

   // Strict compare keeps equal values in arrival order; an empty cell counts as +inf.
   assign greater = !valid_ff || (new_value < value_ff);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift_out) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (ctrl.insert) begin
         if (prev_greater) begin
            value_in = prev_value;
            valid_in = prev_valid;
         end else if (greater) begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

   `BUMS_ASSERT_SAME(a_contiguous, clock, reset, !prev_valid, !valid_ff,
      "cell occupied behind an empty neighbor")
   `BUMS_ASSERT_SAME(a_ordered, clock, reset, prev_valid && valid_ff,
      prev_value <= value_ff, "chain out of ascending order")
   `BUMS_ASSERT_NEXT(a_insert_lands, clock, reset,
      ctrl.insert && !ctrl.shift_out && greater && !prev_greater,
      valid_ff && (value_ff == $past(new_value)), "inserted value not captured")

endmodule

`default_nettype wire

[dv/bottom_up_merge_sorter_tb.sv]
`timescale 1ns / 1ps

module bottom_up_merge_sorter_tb;
   import bums_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
   localparam int RANDOM_ITEMS = 350;     // input transactions for the random part
   localparam int DRAIN_CYCLES = 2 * SIZE + 16;

   // One expected result: a sorted value with its batch markers.
   typedef struct packed {
      bums_data_type value;
      logic          last;
      logic          overflow;
   } sorted_result_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   bums_data_type req_value;
   logic          req_last;
   logic          rsp_valid;
   logic          rsp_ready;
   bums_data_type rsp_sorted_value;
   logic          rsp_last_out;
   logic          rsp_overflow;

   // Predictor state: the values of the open batch in arrival order,
   // and whether any value of that batch hit a full store.
   bums_data_type     batch_values[$];
   bit                batch_dropped;
   // Sorted results still owed by the block, oldest first.
   sorted_result_type owed_results[$];

   bit idle_enable = 1'b1;  // clear for back-to-back stretches on both sides
   int cycle_count = 0;
   int error_count = 0;
   int items_sent = 0;
   int batches_sent = 0;
   int overflow_batches = 0;
   int results_checked = 0;

   bottom_up_merge_sorter i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   always #4 clock = ~clock;

   // Watchdog: end the run as failed if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still owed",
                  cycle_count, owed_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Update the predictor with one accepted input transaction. On the
   // batch end, sort the held values and queue one result per value.
   function automatic void collect_value(input bums_data_type value, input logic last);
      bums_data_type     ordered[$];
      sorted_result_type entry;
      int                pos;
      // Store while there is room; past capacity drop the value and flag it,
      // even when it carries the batch end.
      if (batch_values.size() < SIZE)
         batch_values.push_back(value);
      else
         batch_dropped = 1'b1;
      if (!last)
         return;
      // Stable insertion: walk back only past strictly greater values, so an
      // equal value lands behind those that arrived earlier.
      foreach (batch_values[i]) begin
         pos = ordered.size();
         while (pos > 0 && ordered[pos-1] > batch_values[i])
            pos--;
         ordered.insert(pos, batch_values[i]);
      end
      foreach (ordered[i]) begin
         entry.value    = ordered[i];
         entry.last     = (i == ordered.size() - 1);
         entry.overflow = batch_dropped;
         owed_results.push_back(entry);
      end
      batches_sent++;
      if (batch_dropped)
         overflow_batches++;
      batch_values.delete();
      batch_dropped = 1'b0;
   endfunction

   // Send one input transaction: idle for a random gap, then hold valid and
   // payload until the block takes it. With no gap, valid stays high from
   // the previous transaction, so it is never lowered and raised in one step.
   task automatic send_value(input bums_data_type value, input logic last);
      int gap;
      gap = idle_enable ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_last  <= last;
      do
         @(posedge clock);
      while (!req_ready);
      items_sent++;
      collect_value(value, last);
   endtask

   // Send a whole batch, marking the final value as the batch end.
   task automatic send_batch(input bums_data_type values[$]);
      foreach (values[i])
         send_value(values[i], i == values.size() - 1);
   endtask

   // Draw a value: mostly full-range, some from a narrow band to force ties,
   // some from the signed extremes and the zero crossing.
   function automatic bums_data_type random_value();
      case ($urandom_range(0, 5))
         0: return bums_data_type'($urandom_range(0, 7) - 4);
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return bums_data_type'($urandom);
      endcase
   endfunction

   task automatic send_random_batch(input int count);
      bums_data_type values[$];
      repeat (count) values.push_back(random_value());
      send_batch(values);
   endtask

   // Result side: stall a random number of cycles before each transaction,
   // then hold ready until one is taken.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = idle_enable ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do
            @(posedge clock);
         while (rsp_valid !== 1'b1);
      end
   end

   // Compare every result transaction against the oldest owed result.
   always @(posedge clock) begin
      sorted_result_type owed;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (owed_results.size() == 0) begin
            $error("Result with none owed: sorted_value %0d last_out %0b overflow %0b",
                   rsp_sorted_value, rsp_last_out, rsp_overflow);
            error_count++;
         end else begin
            owed = owed_results.pop_front();
            results_checked++;
            if (rsp_sorted_value !== owed.value) begin
               $error("sorted_value: expected %0d, got %0d", owed.value, rsp_sorted_value);
               error_count++;
            end
            if (rsp_last_out !== owed.last) begin
               $error("last_out: expected %0b, got %0b", owed.last, rsp_last_out);
               error_count++;
            end
            if (rsp_overflow !== owed.overflow) begin
               $error("overflow: expected %0b, got %0b", owed.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   // Smallest possible batch: one value that is also the batch end.
   task automatic test_single_value();
      send_batch('{32'h8000_0000});
   endtask

   // Both signed extremes, zero and its neighbors, in reverse-ish order.
   task automatic test_signed_extremes();
      send_batch('{32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000,
                   32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
   endtask

   // Ties: equal values must leave in arrival order around a distinct one.
   task automatic test_equal_values();
      send_batch('{32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0005, 32'h0000_0005});
   endtask

   // Fill the store exactly, then overrun it with the batch end on a value
   // that is dropped, then overrun it by several values.
   task automatic test_store_full();
      send_random_batch(SIZE);
      send_random_batch(SIZE + 1);
      send_random_batch(SIZE + 4);
   endtask

   // Back-to-back transactions on both channels, no idling anywhere.
   task automatic test_back_to_back();
      idle_enable = 1'b0;
      repeat (4) send_random_batch($urandom_range(1, SIZE));
      send_random_batch(SIZE + 2);
      idle_enable = 1'b1;
   endtask

   // Random batches: mostly in-range sizes, some exactly full, some over,
   // with occasional stretches of no idling.
   task automatic test_random_batches();
      int target;
      int pick;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         idle_enable = ($urandom_range(0, 7) != 0);
         pick = $urandom_range(0, 9);
         if (pick == 0)
            send_random_batch($urandom_range(SIZE + 1, SIZE + 5));
         else if (pick == 1)
            send_random_batch(SIZE);
         else if (pick == 2)
            send_random_batch($urandom_range(1, 3));
         else
            send_random_batch($urandom_range(1, SIZE));
      end
      idle_enable = 1'b1;
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      req_last  = 1'b0;
      batch_dropped = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_value();
      test_signed_extremes();
      test_equal_values();
      test_store_full();
      test_back_to_back();
      test_random_batches();
      req_valid <= 1'b0;

      // Drain: wait for every owed result, then watch for strays.
      while (owed_results.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d values in %0d batches, %0d of which overran the store.",
               items_sent, batches_sent, overflow_batches);
      $display("Checked %0d sorted results with random stalls on both sides.",
               results_checked);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
